[sv/vcp_pkg.sv]
// Shared constants, types and command structs for the circle particle step block.
package vcp_pkg;

	localparam int MAX_CIRCLES = 64;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W = $clog2(MAX_CIRCLES);
	localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
	localparam int PRE_SHIFT = (FRAC_BITS > 22) ? FRAC_BITS - 22 : 0;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] REG_GRAVITY = 3'd0;
	localparam logic [2:0] REG_TOP = 3'd1;
	localparam logic [2:0] REG_LEFT = 3'd2;
	localparam logic [2:0] REG_RIGHT = 3'd3;
	localparam logic [2:0] REG_BOTTOM = 3'd4;

	localparam logic KIND_POS = 1'b0;
	localparam logic KIND_FULL = 1'b1;

	typedef struct packed {
		logic add;
		logic adv;
		logic pair;
		logic emit;
	} vcp_cmd_t;

	typedef struct packed {
		logic done;
	} vcp_stat_t;

	// Saturate a 40-bit signed value into the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		begin
			hi = 40'sd2147483647;
			lo = -40'sd2147483648;
			if (v > hi) sat32 = 32'h7fffffff;
			else if (v < lo) sat32 = 32'h80000000;
			else sat32 = v[31:0];
		end
	endfunction

endpackage

[sv/vcp_ctrl.sv]
// Controller: sequences add, tick phases and the emit sweep.
module vcp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           op,
	input  logic                 full,
	input  logic                 empty,
	input  vcp_pkg::vcp_stat_t   stat,
	output logic                 busy,
	output logic                 refuse,
	output logic                 clear,
	output vcp_pkg::vcp_cmd_t    cmd
);
	import vcp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADD  = 5'b00010,
		S_ADV  = 5'b00100,
		S_PAIR = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	logic   take;

	assign take = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign refuse = take && (op == OP_ADD) && full;
	assign clear = take && (op == OP_CLEAR);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_ADD:   cmd.add = 1'b1;
			S_ADV:   cmd.adv = 1'b1;
			S_PAIR:  cmd.pair = 1'b1;
			S_EMIT:  cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	// Advance through phases as the datapath reports each one done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take && op == OP_ADD && !full) state_q <= S_ADD;
					else if (take && op == OP_TICK && !empty) state_q <= S_ADV;
				end
				S_ADD:  state_q <= S_IDLE;
				S_ADV:  if (stat.done) state_q <= S_PAIR;
				S_PAIR: if (stat.done) state_q <= S_EMIT;
				S_EMIT: if (stat.done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/vcp_dp.sv]
// Datapath: circle store, integration, floor clamp, pair separation, emit.
module vcp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [11:0]                 pointer_x,
	input  logic [11:0]                 pointer_y,
	input  logic [7:0]                  new_radius,
	input  logic                        clear,
	input  vcp_pkg::vcp_cmd_t           cmd,
	input  logic [20:0]                 grav,
	input  logic [11:0]                 ftop,
	input  logic [11:0]                 fleft,
	input  logic [11:0]                 fright,
	input  logic [11:0]                 fbot,
	output vcp_pkg::vcp_stat_t          stat,
	output logic                        full,
	output logic                        empty,
	output logic                        emit_valid,
	output logic [vcp_pkg::IDX_W-1:0]   emit_idx,
	output logic signed [31:0]          emit_x,
	output logic signed [31:0]          emit_y,
	output logic                        emit_last
);
	import vcp_pkg::*;

	logic signed [31:0] nx_mem [MAX_CIRCLES];
	logic signed [31:0] ny_mem [MAX_CIRCLES];
	logic signed [31:0] px_mem [MAX_CIRCLES];
	logic signed [31:0] py_mem [MAX_CIRCLES];
	logic [7:0]         rad_mem [MAX_CIRCLES];

	logic [CNT_W-1:0] count_q;
	logic [11:0] ax_q, ay_q;
	logic [7:0]  ar_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic [4:0] step_q;
	logic signed [31:0] xi_q, yi_q, xj_q, yj_q;
	logic [7:0] ri_q, rj_q;
	logic signed [31:0] cx_q, cy_q, qx_q, qy_q;
	logic [63:0] rem_q, root_q, bit_q;
	logic [31:0] sx_q, sy_q;
	logic [63:0] num_q, dividend_q, quot_q, dvr_q;
	logic [6:0]  dcnt_q;
	logic [31:0] ox_q, oy_q, dist_q, delta_q;
	logic sgnx_q, sgny_q, doy_q;
	logic ev_q, el_q;
	logic [IDX_W-1:0] ei_q;
	logic signed [31:0] ex_q, ey_q;

	localparam logic [4:0] P_LD = 5'd0, P_RD = 5'd1, P_CHK = 5'd2, P_SQ = 5'd3,
		P_RT = 5'd4, P_DV0 = 5'd5, P_DV = 5'd6, P_WR = 5'd7, P_NX = 5'd8,
		P_SQ2 = 5'd9, P_ADD2 = 5'd10;

	logic [CNT_W-1:0] last_idx;
	logic signed [39:0] dx_w, dy_w;
	logic [39:0] adx_w, ady_w;
	logic signed [39:0] rr_w;
	logic signed [39:0] rfix_w, lid_w;
	logic signed [39:0] lft_w, rgt_w, bfix_w;
	logic signed [39:0] vx_w, vy_w;
	logic signed [31:0] nxs_w, nys_w;
	logic clamp_w;
	logic [63:0] sum_w;

	assign full = (count_q >= CNT_W'(MAX_CIRCLES));
	assign empty = (count_q == '0);
	assign last_idx = count_q - 1'b1;

	// Capture add operands.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			ax_q <= pointer_x;
			ay_q <= pointer_y;
			ar_q <= new_radius;
		end
	end

	// Pair geometry.
	assign dx_w = 40'(xi_q) - 40'(xj_q);
	assign dy_w = 40'(yi_q) - 40'(yj_q);
	assign adx_w = dx_w[39] ? 40'(-dx_w) : 40'(dx_w);
	assign ady_w = dy_w[39] ? 40'(-dy_w) : 40'(dy_w);
	assign rr_w = 40'({9'd0, ri_q} + {9'd0, rj_q}) <<< FRAC_BITS;
	assign sum_w = 64'(sx_q) * 64'(sx_q) + 64'(sy_q) * 64'(sy_q);

	// Integration and floor clamp for one circle; all bounds compare signed.
	assign vx_w = 40'(cx_q) - 40'(qx_q);
	assign vy_w = 40'(cy_q) - 40'(qy_q);
	assign nxs_w = sat32(40'(cx_q) + vx_w);
	assign nys_w = sat32(40'(cy_q) + vy_w + 40'(grav));
	assign rfix_w = 40'(ri_q) <<< FRAC_BITS;
	assign lid_w = (40'(ftop) <<< FRAC_BITS) - (rfix_w <<< 1);
	assign lft_w = (40'(fleft) <<< FRAC_BITS) - rfix_w;
	assign rgt_w = (40'(fright) <<< FRAC_BITS) - rfix_w;
	assign bfix_w = 40'(fbot) <<< FRAC_BITS;
	assign clamp_w = (40'(nys_w) > lid_w) &&
		(40'(nxs_w) > lft_w) &&
		(40'(nxs_w) < rgt_w) &&
		(40'(nys_w) < bfix_w);

	// Count of stored circles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (clear) count_q <= '0;
		else if (cmd.add) count_q <= count_q + 1'b1;
	end

	// Phase sequencing counters and sequential arithmetic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			step_q <= P_LD;
			stat <= '0;
			ev_q <= 1'b0;
		end else begin
			stat <= '0;
			ev_q <= 1'b0;
			if (cmd.add) begin
				nx_mem[count_q[IDX_W-1:0]] <= sat32((40'(ax_q) - 40'(ar_q)) <<< FRAC_BITS);
				ny_mem[count_q[IDX_W-1:0]] <= sat32((40'(ay_q) - 40'(ar_q)) <<< FRAC_BITS);
				px_mem[count_q[IDX_W-1:0]] <= sat32((40'(ax_q) - 40'(ar_q)) <<< FRAC_BITS);
				py_mem[count_q[IDX_W-1:0]] <= sat32((40'(ay_q) - 40'(ar_q)) <<< FRAC_BITS);
				rad_mem[count_q[IDX_W-1:0]] <= ar_q;
			end else if (cmd.adv && !stat.done) begin
				case (step_q)
					P_LD: begin
						cx_q <= nx_mem[i_q];
						cy_q <= ny_mem[i_q];
						qx_q <= px_mem[i_q];
						qy_q <= py_mem[i_q];
						ri_q <= rad_mem[i_q];
						step_q <= P_RD;
					end
					P_RD: begin
						px_mem[i_q] <= cx_q;
						py_mem[i_q] <= cy_q;
						nx_mem[i_q] <= nxs_w;
						ny_mem[i_q] <= clamp_w ? sat32(lid_w) : nys_w;
						step_q <= P_LD;
						if (CNT_W'(i_q) == last_idx) begin
							i_q <= '0;
							j_q <= IDX_W'(1);
							stat.done <= 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
					default: step_q <= P_LD;
				endcase
			end else if (cmd.pair && !stat.done) begin
				case (step_q)
					P_LD: begin
						if (count_q < CNT_W'(2)) begin
							stat.done <= 1'b1;
							i_q <= '0;
						end else begin
							xi_q <= nx_mem[i_q];
							yi_q <= ny_mem[i_q];
							ri_q <= rad_mem[i_q];
							xj_q <= nx_mem[j_q];
							yj_q <= ny_mem[j_q];
							rj_q <= rad_mem[j_q];
							step_q <= P_CHK;
						end
					end
					P_CHK: begin
						sgnx_q <= dx_w[39];
						sgny_q <= dy_w[39];
						if (adx_w >= 40'(rr_w) || ady_w >= 40'(rr_w)) begin
							step_q <= P_NX;
						end else begin
							sx_q <= 32'(adx_w >> PRE_SHIFT);
							sy_q <= 32'(ady_w >> PRE_SHIFT);
							step_q <= P_SQ;
						end
					end
					P_SQ: begin
						rem_q <= sum_w;
						root_q <= '0;
						bit_q <= 64'd1 << 62;
						step_q <= P_RT;
					end
					P_RT: begin
						// One root digit per cycle.
						if (bit_q == '0) begin
							step_q <= P_SQ2;
						end else if (bit_q > rem_q && root_q == '0) begin
							bit_q <= bit_q >> 2;
						end else if (rem_q >= root_q + bit_q) begin
							rem_q <= rem_q - (root_q + bit_q);
							root_q <= (root_q >> 1) + bit_q;
							bit_q <= bit_q >> 2;
						end else begin
							root_q <= root_q >> 1;
							bit_q <= bit_q >> 2;
						end
					end
					P_SQ2: begin
						if (root_q == '0 || 40'(root_q << PRE_SHIFT) >= rr_w) begin
							step_q <= P_NX;
						end else begin
							dist_q <= 32'(root_q);
							delta_q <= 32'(rr_w - 40'(root_q << PRE_SHIFT));
							doy_q <= 1'b0;
							step_q <= P_DV0;
						end
					end
					P_DV0: begin
						num_q <= 64'(delta_q) * 64'(doy_q ? sy_q : sx_q);
						step_q <= P_ADD2;
					end
					P_ADD2: begin
						dividend_q <= num_q;
						dvr_q <= {31'd0, dist_q, 1'b0};
						quot_q <= '0;
						rem_q <= '0;
						dcnt_q <= 7'd64;
						step_q <= P_DV;
					end
					P_DV: begin
						// Restoring division, one quotient bit per cycle.
						if (dcnt_q == '0) begin
							if (doy_q) begin
								oy_q <= 32'(quot_q);
								step_q <= P_WR;
							end else begin
								ox_q <= 32'(quot_q);
								doy_q <= 1'b1;
								step_q <= P_DV0;
							end
						end else begin
							if ({rem_q[62:0], dividend_q[63]} >= dvr_q) begin
								rem_q <= {rem_q[62:0], dividend_q[63]} - dvr_q;
								quot_q <= {quot_q[62:0], 1'b1};
							end else begin
								rem_q <= {rem_q[62:0], dividend_q[63]};
								quot_q <= {quot_q[62:0], 1'b0};
							end
							dividend_q <= dividend_q << 1;
							dcnt_q <= dcnt_q - 1'b1;
						end
					end
					P_WR: begin
						nx_mem[i_q] <= sat32(sgnx_q ? 40'(xi_q) - 40'(ox_q) : 40'(xi_q) + 40'(ox_q));
						ny_mem[i_q] <= sat32(sgny_q ? 40'(yi_q) - 40'(oy_q) : 40'(yi_q) + 40'(oy_q));
						nx_mem[j_q] <= sat32(sgnx_q ? 40'(xj_q) + 40'(ox_q) : 40'(xj_q) - 40'(ox_q));
						ny_mem[j_q] <= sat32(sgny_q ? 40'(yj_q) + 40'(oy_q) : 40'(yj_q) - 40'(oy_q));
						step_q <= P_NX;
					end
					P_NX: begin
						step_q <= P_LD;
						if (CNT_W'(j_q) == last_idx) begin
							if (CNT_W'(i_q) + 2'd2 >= count_q) begin
								i_q <= '0;
								stat.done <= 1'b1;
							end else begin
								i_q <= i_q + 1'b1;
								j_q <= i_q + 2'd2;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					default: step_q <= P_LD;
				endcase
			end else if (cmd.emit && !stat.done) begin
				ev_q <= 1'b1;
				ei_q <= i_q;
				ex_q <= nx_mem[i_q];
				ey_q <= ny_mem[i_q];
				el_q <= (CNT_W'(i_q) == last_idx);
				if (CNT_W'(i_q) == last_idx) begin
					i_q <= '0;
					stat.done <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign emit_valid = ev_q;
	assign emit_idx = ei_q;
	assign emit_x = ex_q;
	assign emit_y = ey_q;
	assign emit_last = el_q;

endmodule

[sv/verlet_circle_particle_step.sv]
// Top level of the Verlet circle particle step block.
// Usage: pulse start with op and operands while busy is low; the word is
// taken at that edge. op add stores a circle at pointer minus radius, at
// rest; when the store already holds its limit, one result word comes with
// kind 1, slot 0, zero positions and last set, in the following cycle. op clear
// empties the store at once. op tick integrates every circle, clamps it on
// the floor, separates every overlapping pair in index order, and then
// reports one word per circle (kind 0), last on the final one.
// Results sit on the ports for one cycle, marked by valid; the receiver
// cannot stall them. A tick integrates each circle, then checks each pair:
// pairs apart on an axis are skipped, a digit-serial root skips pairs
// with no contact, and overlapping pairs take two 64-step restoring
// divides; the emit sweep follows, with a hand-over between phases. The
// user writes registers through cfg_we/cfg_index/cfg_data only while idle;
// the block itself does not enforce this.
// Reset empties the store and loads the default floor and gravity.
module verlet_circle_particle_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic [11:0]               pointer_x,
	input  logic [11:0]               pointer_y,
	input  logic [7:0]                new_radius,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [20:0]               cfg_data,
	output logic                      valid,
	output logic                      kind,
	output logic [5:0]                slot,
	output logic signed [31:0]        pos_x,
	output logic signed [31:0]        pos_y,
	output logic                      last
);
	import vcp_pkg::*;

	logic [20:0] grav_q;
	logic [11:0] top_q, left_q, right_q, bot_q;
	logic refuse, clear, full, empty, rf_q;
	vcp_cmd_t cmd;
	vcp_stat_t stat;
	logic ev;
	logic [IDX_W-1:0] ei;
	logic signed [31:0] ex, ey;
	logic el;

	// Hold configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 21'd49152;
			top_q <= 12'd700;
			left_q <= 12'd150;
			right_q <= 12'd750;
			bot_q <= 12'd705;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAVITY: grav_q <= cfg_data;
				REG_TOP:     top_q <= cfg_data[11:0];
				REG_LEFT:    left_q <= cfg_data[11:0];
				REG_RIGHT:   right_q <= cfg_data[11:0];
				REG_BOTTOM:  bot_q <= cfg_data[11:0];
				default:     ;
			endcase
		end
	end

	// Register the refusal word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rf_q <= 1'b0;
		else rf_q <= refuse;
	end

	vcp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .full(full),
		.empty(empty), .stat(stat), .busy(busy), .refuse(refuse),
		.clear(clear), .cmd(cmd)
	);

	vcp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pointer_x(pointer_x), .pointer_y(pointer_y), .new_radius(new_radius),
		.clear(clear), .cmd(cmd), .grav(grav_q), .ftop(top_q), .fleft(left_q),
		.fright(right_q), .fbot(bot_q), .stat(stat), .full(full), .empty(empty),
		.emit_valid(ev), .emit_idx(ei), .emit_x(ex), .emit_y(ey), .emit_last(el)
	);

	// Drive the result word.
	assign valid = ev || rf_q;
	assign kind = rf_q ? KIND_FULL : KIND_POS;
	assign slot = rf_q ? 6'd0 : 6'(ei);
	assign pos_x = rf_q ? 32'sd0 : ex;
	assign pos_y = rf_q ? 32'sd0 : ey;
	assign last = rf_q ? 1'b1 : el;

endmodule

[tb/sv/tb_verlet_circle_particle_step.sv]
// Testbench for the Verlet circle particle step block, with a built-in predictor.
module tb_verlet_circle_particle_step;
	import vcp_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  rad;
	} cmd_t;

	typedef struct {
		logic        kind;
		logic [5:0]  slot;
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} word_t;

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = OP_CLEAR;
	logic [11:0] pointer_x = '0;
	logic [11:0] pointer_y = '0;
	logic [7:0] new_radius = 8'd1;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_GRAVITY;
	logic [20:0] cfg_data = '0;
	logic busy, valid, kind, last;
	logic [5:0] slot;
	logic signed [31:0] pos_x, pos_y;

	verlet_circle_particle_step i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.pointer_x(pointer_x), .pointer_y(pointer_y), .new_radius(new_radius),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.valid(valid), .kind(kind), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: positions, radii, count and register copies
	longint now_x_m[MAX_CIRCLES], now_y_m[MAX_CIRCLES];
	longint old_x_m[MAX_CIRCLES], old_y_m[MAX_CIRCLES];
	int rad_m[MAX_CIRCLES];
	int count_m = 0;
	longint grav_m = 49152, top_m = 700, left_m = 150, right_m = 750, bottom_m = 705;

	cmd_t cmd_q[$];
	word_t expected_words[$];
	int err_count = 0;
	int gen_count = 0;
	bit calm = 0;
	int gap = 0;
	cmd_t cur;

	function automatic longint clip_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Move one circle and clamp it onto the floor
	task automatic integrate(int i);
		longint vx, vy, r, lid;
		vx = now_x_m[i] - old_x_m[i];
		vy = now_y_m[i] - old_y_m[i];
		r = rad_m[i] * ONE;
		old_x_m[i] = now_x_m[i];
		old_y_m[i] = now_y_m[i];
		now_x_m[i] = clip_s32(now_x_m[i] + vx);
		now_y_m[i] = clip_s32(now_y_m[i] + vy + grav_m);
		lid = top_m * ONE - 2 * r;
		if (now_y_m[i] > lid && now_x_m[i] > left_m * ONE - r &&
				now_x_m[i] < right_m * ONE - r && now_y_m[i] < bottom_m * ONE)
			now_y_m[i] = clip_s32(lid);
	endtask

	// Push an overlapping pair apart along the line between them
	task automatic separate_pair(int i, int j);
		longint dx, dy, rr, ax, ay, span, delta, ox, oy;
		dx = now_x_m[i] - now_x_m[j];
		dy = now_y_m[i] - now_y_m[j];
		rr = (rad_m[i] + rad_m[j]) * ONE;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax >= rr || ay >= rr) return;
		span = int_root(ax * ax + ay * ay);
		if (span == 0 || span >= rr) return;
		delta = rr - span;
		ox = (delta * ax) / (2 * span);
		oy = (delta * ay) / (2 * span);
		if (dx < 0) ox = -ox;
		if (dy < 0) oy = -oy;
		now_x_m[i] = clip_s32(now_x_m[i] + ox);
		now_y_m[i] = clip_s32(now_y_m[i] + oy);
		now_x_m[j] = clip_s32(now_x_m[j] - ox);
		now_y_m[j] = clip_s32(now_y_m[j] - oy);
	endtask

	// Apply one accepted word to the predictor and queue its results
	task automatic predict_word(cmd_t c);
		word_t w;
		if (c.op == OP_ADD) begin
			if (count_m >= MAX_CIRCLES) begin
				w.kind = KIND_FULL; w.slot = '0; w.x = '0; w.y = '0; w.last = 1'b1;
				expected_words.insert(expected_words.size(), w);
			end else begin
				now_x_m[count_m] = clip_s32((longint'(c.px) - c.rad) * ONE);
				now_y_m[count_m] = clip_s32((longint'(c.py) - c.rad) * ONE);
				old_x_m[count_m] = now_x_m[count_m];
				old_y_m[count_m] = now_y_m[count_m];
				rad_m[count_m] = c.rad;
				count_m++;
			end
		end else if (c.op == OP_CLEAR) begin
			count_m = 0;
		end else if (c.op == OP_TICK) begin
			for (int i = 0; i < count_m; i++) integrate(i);
			for (int i = 0; i + 1 < count_m; i++)
				for (int j = i + 1; j < count_m; j++) separate_pair(i, j);
			for (int i = 0; i < count_m; i++) begin
				w.kind = KIND_POS;
				w.slot = i[5:0];
				w.x = now_x_m[i][31:0];
				w.y = now_y_m[i][31:0];
				w.last = (i + 1 == count_m);
				expected_words.insert(expected_words.size(), w);
			end
		end
	endtask

	function automatic int pick_gap();
		int k;
		if (calm) return 0;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: present queued words, hold until taken, then idle a while
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) predict_word(cur);
			if (!(start && busy)) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					cur = cmd_q.pop_front();
					op <= cur.op;
					pointer_x <= cur.px;
					pointer_y <= cur.py;
					new_radius <= cur.rad;
					start <= 1'b1;
					gap = pick_gap();
				end else start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		word_t w;
		if (arst_n && valid) begin
			if (expected_words.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected word: kind %0d slot %0d x %0d y %0d last %0d",
						kind, slot, pos_x, pos_y, last);
			end else begin
				w = expected_words.pop_front();
				if (kind !== w.kind || slot !== w.slot || pos_x !== w.x ||
						pos_y !== w.y || last !== w.last) begin
					err_count++;
					if (err_count <= 10) begin
						$write("mismatch: exp kind %0d slot %0d x %0d y %0d last %0d,",
							w.kind, w.slot, $signed(w.x), $signed(w.y), w.last);
						$display(" got kind %0d slot %0d x %0d y %0d last %0d",
							kind, slot, pos_x, pos_y, last);
					end
				end
			end
		end
	end

	task automatic queue_cmd(logic [1:0] o, int x, int y, int r);
		cmd_t c;
		c.op = o; c.px = x[11:0]; c.py = y[11:0]; c.rad = r[7:0];
		cmd_q.insert(cmd_q.size(), c);
		if (o == OP_ADD && gen_count < MAX_CIRCLES) gen_count++;
		if (o == OP_CLEAR) gen_count = 0;
	endtask

	task automatic drain();
		while (cmd_q.size() > 0 || start || expected_words.size() > 0 || busy)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[20:0];
		case (idx)
			REG_GRAVITY: grav_m = v & 32'h1FFFFF;
			REG_TOP: top_m = v & 32'hFFF;
			REG_LEFT: left_m = v & 32'hFFF;
			REG_RIGHT: right_m = v & 32'hFFF;
			REG_BOTTOM: bottom_m = v & 32'hFFF;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random words: adds (half of them small circles near the floor), ticks, clears and unused ops
	task automatic random_words(int n);
		int k;
		for (int t = 0; t < n; t++) begin
			k = $urandom_range(0, 99);
			if (gen_count >= 8 && k < 50) queue_cmd(OP_CLEAR, 0, 0, 1);
			else if (k < 40) begin
				if ($urandom_range(0, 1))
					queue_cmd(OP_ADD, $urandom_range(100, 800), $urandom_range(550, 720),
						$urandom_range(1, 40));
				else
					queue_cmd(OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(1, 255));
			end else if (k < 88) queue_cmd(OP_TICK, $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(1, 255));
			else if (k < 95) queue_cmd(OP_CLEAR, $urandom_range(0, 4095), 0, 1);
			else queue_cmd(OP_SPARE, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(1, 255));
		end
	endtask

	initial begin
		#300000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty tick, extremes, floor clamp, overlap, coincident pair, unused op
		queue_cmd(OP_TICK, 0, 0, 1);
		queue_cmd(OP_ADD, 0, 0, 255);
		queue_cmd(OP_ADD, 4095, 4095, 1);
		queue_cmd(OP_ADD, 400, 695, 10);
		queue_cmd(OP_ADD, 300, 300, 20);
		queue_cmd(OP_ADD, 310, 300, 20);
		queue_cmd(OP_ADD, 500, 500, 5);
		queue_cmd(OP_ADD, 500, 500, 5);
		queue_cmd(OP_SPARE, 4095, 4095, 255);
		repeat (3) queue_cmd(OP_TICK, 0, 0, 1);
		queue_cmd(OP_CLEAR, 0, 0, 1);
		queue_cmd(OP_TICK, 0, 0, 1);
		queue_cmd(OP_ADD, 2048, 2048, 128);
		queue_cmd(OP_TICK, 0, 0, 1);
		queue_cmd(OP_CLEAR, 0, 0, 1);
		drain();

		// Full store: refused add, one tick over all circles
		calm = 1;
		for (int i = 0; i < MAX_CIRCLES; i++)
			queue_cmd(OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(1, 60));
		queue_cmd(OP_ADD, 1, 2, 3);
		queue_cmd(OP_TICK, 0, 0, 1);
		queue_cmd(OP_CLEAR, 0, 0, 1);
		drain();
		calm = 0;

		// Extreme registers: no gravity, floor at its lowest corner
		write_reg(REG_GRAVITY, 0);
		write_reg(REG_TOP, 0);
		write_reg(REG_LEFT, 0);
		write_reg(REG_RIGHT, 0);
		write_reg(REG_BOTTOM, 0);
		end_writes();
		random_words(5);
		queue_cmd(OP_CLEAR, 0, 0, 1);
		drain();

		// Gravity at half its register range, floor lid far above: a large circle is flung up into saturation
		write_reg(REG_GRAVITY, 1048576);
		write_reg(REG_TOP, 0);
		write_reg(REG_LEFT, 0);
		write_reg(REG_RIGHT, 4095);
		write_reg(REG_BOTTOM, 4095);
		end_writes();
		calm = 1;
		queue_cmd(OP_ADD, 4095, 4095, 1);
		queue_cmd(OP_ADD, 1000, 4000, 255);
		repeat (14) queue_cmd(OP_TICK, 0, 0, 1);
		queue_cmd(OP_CLEAR, 0, 0, 1);
		drain();
		calm = 0;
		random_words(5);
		queue_cmd(OP_CLEAR, 0, 0, 1);
		drain();

		// Back to a typical setting
		write_reg(REG_GRAVITY, 49152);
		write_reg(REG_TOP, 700);
		write_reg(REG_LEFT, 150);
		write_reg(REG_RIGHT, 750);
		write_reg(REG_BOTTOM, 705);
		end_writes();
		random_words(5);
		drain();
		repeat (200) @(posedge clk);

		if (err_count == 0 && expected_words.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
